@@ hw/rtl/pss_pkg.sv @@
// shared types and constants for the pen-up stroke segmenter
`default_nettype none
package pss_pkg;

	localparam int ACCEL_W    = 16;
	localparam int COUNT_W    = 11;
	localparam int THR_W      = 12;
	localparam int WEIGHT_W   = 16;
	localparam int GRAV_W     = 33;
	localparam int DIFF_W     = 35;
	localparam int MULB_W     = 18;
	localparam int PROD_W     = DIFF_W + MULB_W;
	localparam int MAG_W      = 37;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 3 * ACCEL_W;
	localparam int M_TDATA_W  = 16;

	// milli-g per g scale applied to the residual before the shift
	localparam logic signed [MULB_W-1:0] K_MILLI = 18'sd1000;

	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_LAST = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STILL_THR  = 3'd0,
		REG_DWELL      = 3'd1,
		REG_MIN_STROKE = 3'd2,
		REG_MAX_STROKE = 3'd3,
		REG_WEIGHT     = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		CAUSE_OPEN  = 2'd0,
		CAUSE_DWELL = 2'd1,
		CAUSE_FULL  = 2'd2
	} cause_t;

	typedef enum logic [3:0] {
		OP_IDLE     = 4'd0,
		OP_DIFF_IN  = 4'd1,
		OP_MUL_W    = 4'd2,
		OP_UPD_G    = 4'd3,
		OP_DIFF_OUT = 4'd4,
		OP_MUL_K    = 4'd5,
		OP_RES      = 4'd6,
		OP_MUL_SQ   = 4'd7,
		OP_ACC      = 4'd8,
		OP_MUL_T    = 4'd9
	} dp_op_t;

	typedef struct packed {
		logic   load;
		dp_op_t op;
		logic [1:0] axis;
	} dp_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/pss_datapath.sv @@
// gravity filter and residual magnitude datapath around one shared multiplier
`default_nettype none
module pss_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pss_pkg::dp_ctl_t                 ctl,
	input  wire logic [pss_pkg::S_TDATA_W-1:0]    sample,
	input  wire logic [pss_pkg::WEIGHT_W-1:0]     weight,
	input  wire logic [pss_pkg::THR_W-1:0]        still_thr,
	output logic                                  still
);
	import pss_pkg::*;

	logic signed [GRAV_W-1:0] grav_q [3];
	logic [S_TDATA_W-1:0]     smp_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [MAG_W-1:0]         mag_q;

	logic [ACCEL_W-1:0]       accel_sel;
	logic signed [GRAV_W-1:0] grav_sel;
	logic signed [DIFF_W-1:0] s_ext;
	logic signed [DIFF_W-1:0] g_ext;
	logic signed [DIFF_W-1:0] mul_a;
	logic signed [MULB_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;

	always_comb begin
		unique case (ctl.axis)
			AXIS_X: begin
				accel_sel = smp_q[ACCEL_W-1:0];
				grav_sel  = grav_q[0];
			end
			AXIS_Y: begin
				accel_sel = smp_q[2*ACCEL_W-1:ACCEL_W];
				grav_sel  = grav_q[1];
			end
			default: begin
				accel_sel = smp_q[3*ACCEL_W-1:2*ACCEL_W];
				grav_sel  = grav_q[2];
			end
		endcase
	end

	// sample in q16.16 counts, sign-extended to the difference width
	assign s_ext = {{(DIFF_W-ACCEL_W-16){accel_sel[ACCEL_W-1]}}, accel_sel, 16'b0};
	assign g_ext = {{(DIFF_W-GRAV_W){grav_sel[GRAV_W-1]}}, grav_sel};

	always_comb begin
		unique case (ctl.op)
			OP_MUL_T: mul_a = {{(DIFF_W-THR_W){1'b0}}, still_thr};
			default:  mul_a = diff_q;
		endcase
	end

	always_comb begin
		unique case (ctl.op)
			OP_MUL_W:  mul_b = {{(MULB_W-WEIGHT_W){1'b0}}, weight};
			OP_MUL_K:  mul_b = K_MILLI;
			OP_MUL_SQ: mul_b = diff_q[MULB_W-1:0];
			OP_MUL_T:  mul_b = {{(MULB_W-THR_W){1'b0}}, still_thr};
			default:   mul_b = '0;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				grav_q[i] <= '0;
			end
		end else if (ctl.op == OP_UPD_G) begin
			for (int i = 0; i < 3; i++) begin
				// low 33 bits of asr(prod, 16), wrapping like the estimate
				if (ctl.axis == 2'(i)) begin
					grav_q[i] <= grav_sel + prod_q[GRAV_W+15:16];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			smp_q <= sample;
			mag_q <= '0;
		end
		unique case (ctl.op)
			OP_DIFF_IN, OP_DIFF_OUT: diff_q <= s_ext - g_ext;
			OP_MUL_W, OP_MUL_K, OP_MUL_SQ, OP_MUL_T: prod_q <= mul_p;
			// residual in milli-g: asr by 28, fits 18 bits signed
			OP_RES: diff_q <= {{(DIFF_W-MULB_W){prod_q[45]}}, prod_q[45:28]};
			OP_ACC: mag_q <= mag_q + {1'b0, prod_q[MAG_W-2:0]};
			default: ;
		endcase
	end

	// valid after the threshold square lands in prod_q
	assign still = mag_q < {{(MAG_W-2*THR_W){1'b0}}, prod_q[2*THR_W-1:0]};

endmodule
`default_nettype wire

@@ hw/rtl/pen_up_stroke_segmenter.sv @@
// top level: sample stream in, pen-up decision stream out
//
// channel  dir  tdata (low bit up)                tuser         tlast
// s_*      in   accel_x, accel_y, accel_z         new_stroke    -
// m_*      out  samples_in_stroke, zero fill      close_cause   pen_up
// cfg_*    in   write enable, register index, write data
//
// each sample runs eight steps per axis on the shared 35x18 multiplier, then
// one threshold square and a decision step
// s_tready is high only while the sequencer is idle
// a result waits in the output register; a stalled m_tready holds the
// decision step until the register frees up
// arst_n clears gravity estimates, counters and config registers to their reset values
`default_nettype none
module pen_up_stroke_segmenter #(
	parameter int MAX_STROKE_SAMPLES = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [pss_pkg::S_TDATA_W-1:0]      s_tdata,   // accel_x, accel_y, accel_z
	input  wire logic                               s_tuser,   // new_stroke
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [pss_pkg::M_TDATA_W-1:0]           m_tdata,   // samples_in_stroke, zeros
	output logic [1:0]                              m_tuser,   // close_cause
	output logic                                    m_tlast,
	input  wire logic                               cfg_we,
	input  wire logic [pss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pss_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pss_pkg::*;

	localparam int CAP_INT = (MAX_STROKE_SAMPLES > 2047) ? 2047 : MAX_STROKE_SAMPLES;
	localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_INT);
	localparam logic [COUNT_W-1:0] RUN_MAX = '1;

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_DIFF_IN  = 11'b000_0000_0010,
		ST_MUL_W    = 11'b000_0000_0100,
		ST_UPD_G    = 11'b000_0000_1000,
		ST_DIFF_OUT = 11'b000_0001_0000,
		ST_MUL_K    = 11'b000_0010_0000,
		ST_RES      = 11'b000_0100_0000,
		ST_MUL_SQ   = 11'b000_1000_0000,
		ST_ACC      = 11'b001_0000_0000,
		ST_MUL_T    = 11'b010_0000_0000,
		ST_DECIDE   = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	logic [1:0] axis_q;

	logic [THR_W-1:0]    thr_q;
	logic [COUNT_W-1:0]  dwell_q;
	logic [COUNT_W-1:0]  min_q;
	logic [COUNT_W-1:0]  max_q;
	logic [WEIGHT_W-1:0] weight_q;

	logic [COUNT_W-1:0] stroke_count_q;
	logic [COUNT_W-1:0] still_run_q;

	logic               out_valid_q;
	logic               out_last_q;
	cause_t             out_cause_q;
	logic [COUNT_W-1:0] out_count_q;

	dp_ctl_t            ctl;
	logic               still;
	logic               in_beat;
	logic               out_free;
	logic [COUNT_W-1:0] count_base;
	logic [COUNT_W-1:0] run_next;
	logic [COUNT_W-1:0] full_at;
	cause_t             cause;

	assign in_beat  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_W'(60);
			dwell_q  <= COUNT_W'(40);
			min_q    <= COUNT_W'(32);
			max_q    <= COUNT_W'(1024);
			weight_q <= WEIGHT_W'(1311);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STILL_THR:  thr_q    <= cfg_data[THR_W-1:0];
				REG_DWELL:      dwell_q  <= cfg_data[COUNT_W-1:0];
				REG_MIN_STROKE: min_q    <= cfg_data[COUNT_W-1:0];
				REG_MAX_STROKE: max_q    <= cfg_data[COUNT_W-1:0];
				REG_WEIGHT:     weight_q <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AXIS_X;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_DIFF_IN;
						axis_q  <= AXIS_X;
					end
				end
				ST_DIFF_IN:  state_q <= ST_MUL_W;
				ST_MUL_W:    state_q <= ST_UPD_G;
				ST_UPD_G:    state_q <= ST_DIFF_OUT;
				ST_DIFF_OUT: state_q <= ST_MUL_K;
				ST_MUL_K:    state_q <= ST_RES;
				ST_RES:      state_q <= ST_MUL_SQ;
				ST_MUL_SQ:   state_q <= ST_ACC;
				ST_ACC: begin
					if (axis_q == AXIS_LAST) begin
						state_q <= ST_MUL_T;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_DIFF_IN;
					end
				end
				ST_MUL_T:    state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.load = in_beat;
		ctl.axis = axis_q;
		unique case (state_q)
			ST_DIFF_IN:  ctl.op = OP_DIFF_IN;
			ST_MUL_W:    ctl.op = OP_MUL_W;
			ST_UPD_G:    ctl.op = OP_UPD_G;
			ST_DIFF_OUT: ctl.op = OP_DIFF_OUT;
			ST_MUL_K:    ctl.op = OP_MUL_K;
			ST_RES:      ctl.op = OP_RES;
			ST_MUL_SQ:   ctl.op = OP_MUL_SQ;
			ST_ACC:      ctl.op = OP_ACC;
			ST_MUL_T:    ctl.op = OP_MUL_T;
			default:     ctl.op = OP_IDLE;
		endcase
	end

	pss_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sample    (s_tdata),
		.weight    (weight_q),
		.still_thr (thr_q),
		.still     (still)
	);

	assign count_base = s_tuser ? '0 : stroke_count_q;
	assign run_next   = still ? ((still_run_q < RUN_MAX) ? still_run_q + 1'b1 : still_run_q)
	                          : '0;
	assign full_at    = (max_q > CAP) ? CAP : max_q;

	always_comb begin
		priority if (still && run_next >= dwell_q && stroke_count_q >= min_q) begin
			cause = CAUSE_DWELL;
		end else if (stroke_count_q >= full_at) begin
			cause = CAUSE_FULL;
		end else begin
			cause = CAUSE_OPEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stroke_count_q <= '0;
			still_run_q    <= '0;
		end else if (in_beat) begin
			// new stroke clears the counts before this sample is counted
			stroke_count_q <= (count_base < CAP) ? count_base + 1'b1 : count_base;
			if (s_tuser) begin
				still_run_q <= '0;
			end
		end else if (state_q == ST_DECIDE && out_free) begin
			if (cause != CAUSE_OPEN) begin
				stroke_count_q <= '0;
				still_run_q    <= '0;
			end else begin
				still_run_q <= run_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DECIDE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && out_free) begin
			out_last_q  <= (cause != CAUSE_OPEN);
			out_cause_q <= cause;
			out_count_q <= stroke_count_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_cause_q;
	assign m_tdata  = {{(M_TDATA_W-COUNT_W){1'b0}}, out_count_q};

	a_pen_up_matches_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser != CAUSE_OPEN)))
		else $error("pen_up disagrees with close cause");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		stroke_count_q <= CAP)
		else $error("stroke count above capacity");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("sequencer took a beat while still working");

	a_full_cause_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == CAUSE_FULL) |-> (out_count_q >= full_at))
		else $error("store-full close below the full limit");

endmodule
`default_nettype wire

@@ tb/pen_up_stroke_segmenter_tb.sv @@
// self-checking stream testbench for the pen-up stroke segmenter
module pen_up_stroke_segmenter_tb;
	import pss_pkg::*;

	localparam int CAPACITY    = 1024;
	localparam int STORE_CAP   = (CAPACITY > 2047) ? 2047 : CAPACITY;
	localparam int RUN_SAT     = 2047;
	localparam int DRAIN_WAIT  = 40;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef struct packed {
		logic signed [ACCEL_W-1:0] az;
		logic signed [ACCEL_W-1:0] ay;
		logic signed [ACCEL_W-1:0] ax;
		logic                      new_stroke;
	} accel_sample_t;

	typedef struct packed {
		logic               pen_up;
		cause_t             cause;
		logic [COUNT_W-1:0] count;
	} stroke_decision_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the registers, at their reset values
	logic [THR_W-1:0]    still_thr = 12'd60;
	logic [COUNT_W-1:0]  dwell_need = 11'd40;
	logic [COUNT_W-1:0]  min_stroke = 11'd32;
	logic [COUNT_W-1:0]  max_stroke = 11'd1024;
	logic [WEIGHT_W-1:0] grav_weight = 16'd1311;

	// predictor state
	logic signed [GRAV_W-1:0] grav_est [3] = '{default: '0};
	int still_len = 0;
	int stroke_len = 0;

	accel_sample_t    sample_q [$];
	stroke_decision_t decision_q [$];
	accel_sample_t    in_flight;
	stroke_decision_t want;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int base_x = 0;
	int base_y = 0;
	int base_z = 4096;

	pen_up_stroke_segmenter #(.MAX_STROKE_SAMPLES(CAPACITY)) dut (.*);

	always #5 clk = ~clk;

	// low-pass update of one axis, returns the residual in milli-g
	function automatic longint track_axis(int axis, logic signed [ACCEL_W-1:0] raw);
		longint s, g;
		s = longint'(raw) * 65536;
		g = longint'(grav_est[axis]);
		g = g + (((s - g) * longint'(grav_weight)) >>> 16);
		grav_est[axis] = g[GRAV_W-1:0];
		return ((s - g) * 1000) >>> 28;
	endfunction

	function automatic stroke_decision_t predict_decision(accel_sample_t smp);
		longint rx, ry, rz, mag, thr2;
		int full_at;
		cause_t cause;
		stroke_decision_t res;
		if (smp.new_stroke) begin
			stroke_len = 0;
			still_len = 0;
		end
		if (stroke_len < STORE_CAP)
			stroke_len++;
		rx = track_axis(0, smp.ax);
		ry = track_axis(1, smp.ay);
		rz = track_axis(2, smp.az);
		mag = rx * rx + ry * ry + rz * rz;
		thr2 = longint'(still_thr) * longint'(still_thr);
		cause = CAUSE_OPEN;
		if (mag < thr2) begin
			if (still_len < RUN_SAT)
				still_len++;
			if (still_len >= int'(dwell_need) && stroke_len >= int'(min_stroke))
				cause = CAUSE_DWELL;
		end else begin
			still_len = 0;
		end
		full_at = (int'(max_stroke) > STORE_CAP) ? STORE_CAP : int'(max_stroke);
		if (cause == CAUSE_OPEN && stroke_len >= full_at)
			cause = CAUSE_FULL;
		res.pen_up = (cause != CAUSE_OPEN);
		res.cause = cause;
		res.count = COUNT_W'(stroke_len);
		if (res.pen_up) begin
			stroke_len = 0;
			still_len = 0;
		end
		return res;
	endfunction

	function automatic int clamp_accel(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic void queue_sample(int x, int y, int z, bit ns);
		accel_sample_t smp;
		smp.ax = ACCEL_W'(clamp_accel(x));
		smp.ay = ACCEL_W'(clamp_accel(y));
		smp.az = ACCEL_W'(clamp_accel(z));
		smp.new_stroke = ns;
		sample_q.push_back(smp);
	endfunction

	function automatic int jitter(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int any_accel();
		return int'($signed(16'($urandom())));
	endfunction

	// mostly hold-still runs around a gravity vector, broken by motion and noise
	task automatic queue_segments(input int target, input bit allow_new);
		int pushed, kind, len, i;
		bit ns;
		pushed = 0;
		while (pushed < target) begin
			kind = $urandom_range(0, 15);
			if (kind >= 13) begin
				base_x = jitter(6000);
				base_y = jitter(6000);
				base_z = jitter(6000);
				kind = 0;
			end
			if (kind <= 8)
				len = $urandom_range(8, 60);
			else if (kind <= 11)
				len = $urandom_range(2, 15);
			else
				len = $urandom_range(1, 4);
			for (i = 0; i < len && pushed < target; i++) begin
				ns = allow_new && (i == 0) && ($urandom_range(0, 5) == 0);
				if (kind <= 8) begin
					queue_sample(base_x + jitter(3), base_y + jitter(3), base_z + jitter(3), ns);
				end else if (kind <= 11) begin
					queue_sample(base_x + jitter(4096), base_y + jitter(4096),
						base_z + jitter(4096), ns);
				end else begin
					ns = allow_new && ($urandom_range(0, 1) == 1);
					queue_sample(any_accel(), any_accel(), any_accel(), ns);
				end
				pushed++;
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_STILL_THR:  still_thr = value[THR_W-1:0];
			REG_DWELL:      dwell_need = value[COUNT_W-1:0];
			REG_MIN_STROKE: min_stroke = value[COUNT_W-1:0];
			REG_MAX_STROKE: max_stroke = value[COUNT_W-1:0];
			REG_WEIGHT:     grav_weight = value[WEIGHT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] thr, dwell, min_len, max_len, weight);
		write_reg(REG_STILL_THR, thr);
		write_reg(REG_DWELL, dwell);
		write_reg(REG_MIN_STROKE, min_len);
		write_reg(REG_MAX_STROKE, max_len);
		write_reg(REG_WEIGHT, weight);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (sample_q.size() > 0 || s_tvalid || decision_q.size() > 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// sample driver, predicts each decision as its beat is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				decision_q.push_back(predict_decision(in_flight));
			if (!s_tvalid || s_tready) begin
				if (sample_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_flight = sample_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {in_flight.az, in_flight.ay, in_flight.ax};
					s_tuser <= in_flight.new_stroke;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// decision monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (decision_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected decision beat: count %0d cause %0d pen_up %0b",
							m_tdata, m_tuser, m_tlast);
				end else begin
					want = decision_q.pop_front();
					if (m_tdata !== {{(M_TDATA_W - COUNT_W){1'b0}}, want.count} ||
					    m_tuser !== want.cause || m_tlast !== want.pen_up) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("decision mismatch: exp count %0d cause %0d pen_up %0b, got count %0d cause %0d pen_up %0b",
								want.count, want.cause, want.pen_up, m_tdata, m_tuser, m_tlast);
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", CYCLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// extremes of every axis under reset settings
		@(negedge clk);
		queue_sample(0, 0, 0, 1'b1);
		queue_sample(32767, -32768, 32767, 1'b0);
		queue_sample(-32768, 32767, -32768, 1'b1);
		queue_sample(0, 0, 0, 1'b0);
		queue_sample(1, -1, 0, 1'b0);
		queue_sample(21845, -21846, 21845, 1'b1);
		queue_sample(-21846, 21845, -21846, 1'b0);
		wait_idle();

		// frozen gravity, dwell and full on the same sample, then full alone
		set_config(16'hFFFF, 16'd2, 16'd0, 16'd2, 16'd0);
		@(negedge clk);
		queue_sample(0, 0, 0, 1'b0);
		queue_sample(0, 0, 0, 1'b0);
		queue_sample(0, 0, 0, 1'b0);
		queue_sample(32767, 32767, 32767, 1'b0);
		queue_sample(0, 0, 0, 1'b1);
		wait_idle();

		// zero max closes every sample, zero dwell lets any still sample close
		set_config(16'd60, 16'd0, 16'd0, 16'd0, 16'd65535);
		@(negedge clk);
		queue_sample(0, 0, 0, 1'b0);
		queue_sample(0, 0, 0, 1'b0);
		queue_sample(32767, 32767, 32767, 1'b0);
		queue_sample(-32768, -32768, -32768, 1'b0);
		queue_sample(0, 0, 0, 1'b1);
		wait_idle();

		// max above the store capacity, and a write to an unmapped index
		set_config(16'd0, 16'd1024, 16'd1024, 16'd2047, 16'd1311);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		@(negedge clk);
		queue_sample(any_accel(), any_accel(), any_accel(), 1'b0);
		queue_sample(any_accel(), any_accel(), any_accel(), 1'b1);
		wait_idle();

		// one stroke runs into the store capacity, never still
		set_config(16'd0, 16'd40, 16'd32, 16'd2047, 16'd0);
		send_idle_pct = 11;
		recv_stall_pct = 11;
		@(negedge clk);
		queue_segments(1040, 1'b0);
		wait_idle();

		set_config(16'd120, 16'd12, 16'd16, 16'd1024, 16'd16384);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		queue_segments(110, 1'b1);
		wait_idle();

		set_config(16'd4095, 16'd1024, 16'd1024, 16'd64, 16'd65535);
		send_idle_pct = 74;
		recv_stall_pct = 0;
		@(negedge clk);
		queue_segments(110, 1'b1);
		wait_idle();

		set_config(16'd60, 16'd1, 16'd0, 16'd1024, 16'd1);
		send_idle_pct = 0;
		recv_stall_pct = 74;
		@(negedge clk);
		queue_segments(110, 1'b1);
		wait_idle();

		set_config(16'($urandom_range(20, 400)), 16'($urandom_range(1, 64)),
			16'($urandom_range(0, 64)), 16'($urandom_range(8, 1024)),
			16'($urandom_range(256, 65535)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		queue_segments(110, 1'b1);
		wait_idle();

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
